// ===== hw/rtl/wav_header_stream_parser_macros.svh =====
// ----------------------------------------------------------------------------
// WAV header stream parser assertion macros
// Shared concurrent assertion forms, clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WAV_HEADER_STREAM_PARSER_MACROS_SVH
`define WAV_HEADER_STREAM_PARSER_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define WHSP_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// A condition that must be accompanied by a consequence in the same cycle.
`define WHSP_IMPLIES(name, cond, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/whsp_pkg.sv =====
// ----------------------------------------------------------------------------
// WAV header stream parser package
// Parser phases, RIFF tags, status codes and the result record types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package whsp_pkg;

    // Parser phases.
    typedef enum logic [3:0] {
        PH_RIFF,
        PH_RSIZE,
        PH_WAVE,
        PH_ID,
        PH_SIZE,
        PH_FMT,
        PH_FMTX,
        PH_SKIP,
        PH_DATA,
        PH_PAD
    } phase_t;

    // Four-character tags as they appear after four little-endian shifts.
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] FMT_MIN_BYTES = 32'd16;
    localparam logic [15:0] PCM_FORMAT    = 16'd1;

    // Result kinds.
    localparam logic KIND_AUDIO  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // Report status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TRUNC   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_NON_PCM = 2'd3;

    // One result item as it leaves the block.
    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte_res;
        logic [1:0]  status;
        logic [15:0] chan_count;
        logic [31:0] samp_rate;
        logic [31:0] bytes_per_sec;
        logic [15:0] frame_bytes;
        logic [15:0] samp_bits;
        logic [31:0] payload_len;
        logic        last;
    } result_t;

    // Up to two results written into the queue for one request.
    typedef struct packed {
        logic    push0;
        logic    push1;
        result_t entry0;
        result_t entry1;
    } push_t;

endpackage

// ===== hw/rtl/whsp_front.sv =====
// ----------------------------------------------------------------------------
// WAV header stream parser front end
// Accepts file bytes, walks the RIFF chunk structure and queues results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module whsp_front import whsp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_command,
    input  logic [7:0] s_data_byte,
    input  logic       q_room,
    output push_t      push
);

    phase_t      phase_reg, phase_next;
    logic [31:0] count_reg, count_next;
    logic [31:0] id_reg, id_next;
    logic [31:0] size_reg, size_next;
    logic [15:0] fmt_code_reg, fmt_code_next;
    logic [15:0] channels_reg, channels_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] brate_reg, brate_next;
    logic [15:0] align_reg, align_next;
    logic [15:0] bits_reg, bits_next;
    logic [31:0] data_len_reg, data_len_next;
    logic        fmt_seen_reg, fmt_seen_next;
    logic        data_seen_reg, data_seen_next;
    logic        done_reg, done_next;

    logic        fire;
    logic [31:0] id_shifted;
    logic [31:0] size_shifted;
    logic        cnt_is1, cnt_is3, cnt_is15;
    logic        size_gt_min;
    logic        at_boundary;
    phase_t      chunk_end_phase;
    logic        rpt_valid;
    logic [1:0]  rpt_status;
    logic        emit_data;
    result_t     rpt_entry;
    result_t     data_entry;

    // A request is taken whenever the queue can absorb two results.
    assign s_ready = q_room;
    assign fire    = s_valid && q_room;

    // Little-endian shift, counter tests and chunk bookkeeping.
    assign id_shifted      = {s_data_byte, id_reg[31:8]};
    assign size_shifted    = {s_data_byte, size_reg[31:8]};
    assign cnt_is1         = (count_reg == 32'd1);
    assign cnt_is3         = (count_reg == 32'd3);
    assign cnt_is15        = (count_reg == 32'd15);
    assign size_gt_min     = (size_reg > FMT_MIN_BYTES);
    assign chunk_end_phase = size_reg[0] ? PH_PAD : PH_ID;
    assign at_boundary     = (((phase_reg == PH_RIFF) || (phase_reg == PH_ID))
                              && (count_reg == 32'd0)) || (phase_reg == PH_PAD);

    // Classify the request: audio byte pass-through and report decisions.
    always_comb begin
        rpt_valid  = 1'b0;
        rpt_status = ST_OK;
        emit_data  = 1'b0;
        if (fire && !done_reg) begin
            if (s_command) begin
                rpt_valid  = 1'b1;
                rpt_status = at_boundary ? ST_INVALID : ST_TRUNC;
            end else begin
                unique case (phase_reg)
                    PH_RIFF: begin
                        if (cnt_is3 && (id_shifted != TAG_RIFF)) begin
                            rpt_valid  = 1'b1;
                            rpt_status = ST_INVALID;
                        end
                    end
                    PH_WAVE: begin
                        if (cnt_is3 && (id_shifted != TAG_WAVE)) begin
                            rpt_valid  = 1'b1;
                            rpt_status = ST_INVALID;
                        end
                    end
                    PH_SIZE: begin
                        if (cnt_is3 && ((size_shifted == 32'd0) ||
                            ((id_reg == TAG_FMT) && (size_shifted < FMT_MIN_BYTES)))) begin
                            rpt_valid  = 1'b1;
                            rpt_status = ST_INVALID;
                        end
                    end
                    PH_FMT: begin
                        if (cnt_is15) begin
                            if (fmt_code_reg != PCM_FORMAT) begin
                                rpt_valid  = 1'b1;
                                rpt_status = ST_NON_PCM;
                            end else if (!size_gt_min && data_seen_reg) begin
                                rpt_valid  = 1'b1;
                                rpt_status = ST_OK;
                            end
                        end
                    end
                    PH_FMTX: begin
                        if (cnt_is1 && data_seen_reg) begin
                            rpt_valid  = 1'b1;
                            rpt_status = ST_OK;
                        end
                    end
                    PH_DATA: begin
                        emit_data = 1'b1;
                        if (cnt_is1 && fmt_seen_reg) begin
                            rpt_valid  = 1'b1;
                            rpt_status = ST_OK;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Next state of the chunk walker and its field registers.
    always_comb begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        id_next        = id_reg;
        size_next      = size_reg;
        fmt_code_next  = fmt_code_reg;
        channels_next  = channels_reg;
        rate_next      = rate_reg;
        brate_next     = brate_reg;
        align_next     = align_reg;
        bits_next      = bits_reg;
        data_len_next  = data_len_reg;
        fmt_seen_next  = fmt_seen_reg;
        data_seen_next = data_seen_reg;
        done_next      = done_reg;
        if (fire) begin
            if (s_command) begin
                // End of stream returns the parser to its reset state.
                phase_next     = PH_RIFF;
                count_next     = '0;
                id_next        = '0;
                size_next      = '0;
                fmt_code_next  = '0;
                channels_next  = '0;
                rate_next      = '0;
                brate_next     = '0;
                align_next     = '0;
                bits_next      = '0;
                data_len_next  = '0;
                fmt_seen_next  = 1'b0;
                data_seen_next = 1'b0;
                done_next      = 1'b0;
            end else if (!done_reg) begin
                unique case (phase_reg)
                    PH_RIFF, PH_WAVE: begin
                        id_next = id_shifted;
                        if (cnt_is3) begin
                            count_next = '0;
                            phase_next = (phase_reg == PH_RIFF) ? PH_RSIZE : PH_ID;
                        end else begin
                            count_next = count_reg + 32'd1;
                        end
                    end
                    PH_RSIZE: begin
                        if (cnt_is3) begin
                            count_next = '0;
                            phase_next = PH_WAVE;
                        end else begin
                            count_next = count_reg + 32'd1;
                        end
                    end
                    PH_ID: begin
                        id_next = id_shifted;
                        if (cnt_is3) begin
                            count_next = '0;
                            phase_next = PH_SIZE;
                        end else begin
                            count_next = count_reg + 32'd1;
                        end
                    end
                    PH_SIZE: begin
                        size_next = size_shifted;
                        if (!cnt_is3) begin
                            count_next = count_reg + 32'd1;
                        end else begin
                            count_next = '0;
                            if (!rpt_valid) begin
                                if (id_reg == TAG_FMT) begin
                                    fmt_code_next = '0;
                                    channels_next = '0;
                                    rate_next     = '0;
                                    brate_next    = '0;
                                    align_next    = '0;
                                    bits_next     = '0;
                                    phase_next    = PH_FMT;
                                end else if (id_reg == TAG_DATA) begin
                                    data_len_next = size_shifted;
                                    count_next    = size_shifted;
                                    phase_next    = PH_DATA;
                                end else begin
                                    count_next = size_shifted;
                                    phase_next = PH_SKIP;
                                end
                            end
                        end
                    end
                    PH_FMT: begin
                        // Place the byte into its field lane.
                        case (count_reg[3:0])
                            4'd0:  fmt_code_next[7:0]  = s_data_byte;
                            4'd1:  fmt_code_next[15:8] = s_data_byte;
                            4'd2:  channels_next[7:0]  = s_data_byte;
                            4'd3:  channels_next[15:8] = s_data_byte;
                            4'd4:  rate_next[7:0]      = s_data_byte;
                            4'd5:  rate_next[15:8]     = s_data_byte;
                            4'd6:  rate_next[23:16]    = s_data_byte;
                            4'd7:  rate_next[31:24]    = s_data_byte;
                            4'd8:  brate_next[7:0]     = s_data_byte;
                            4'd9:  brate_next[15:8]    = s_data_byte;
                            4'd10: brate_next[23:16]   = s_data_byte;
                            4'd11: brate_next[31:24]   = s_data_byte;
                            4'd12: align_next[7:0]     = s_data_byte;
                            4'd13: align_next[15:8]    = s_data_byte;
                            4'd14: bits_next[7:0]      = s_data_byte;
                            default: bits_next[15:8]   = s_data_byte;
                        endcase
                        if (!cnt_is15) begin
                            count_next = count_reg + 32'd1;
                        end else if (fmt_code_reg == PCM_FORMAT) begin
                            if (size_gt_min) begin
                                count_next = size_reg - FMT_MIN_BYTES;
                                phase_next = PH_FMTX;
                            end else begin
                                fmt_seen_next = 1'b1;
                                if (!data_seen_reg) begin
                                    count_next = '0;
                                    phase_next = chunk_end_phase;
                                end
                            end
                        end
                    end
                    PH_FMTX: begin
                        count_next = count_reg - 32'd1;
                        if (cnt_is1) begin
                            fmt_seen_next = 1'b1;
                            if (!data_seen_reg) begin
                                phase_next = chunk_end_phase;
                            end
                        end
                    end
                    PH_SKIP: begin
                        count_next = count_reg - 32'd1;
                        if (cnt_is1) begin
                            phase_next = chunk_end_phase;
                        end
                    end
                    PH_DATA: begin
                        count_next = count_reg - 32'd1;
                        if (cnt_is1) begin
                            data_seen_next = 1'b1;
                            if (!fmt_seen_reg) begin
                                phase_next = chunk_end_phase;
                            end
                        end
                    end
                    default: begin
                        // The pad byte after an odd-sized chunk is dropped.
                        count_next = '0;
                        phase_next = PH_ID;
                    end
                endcase
                if (rpt_valid) begin
                    done_next = 1'b1;
                end
            end
        end
    end

    // Build the queue writes for this request.
    always_comb begin
        rpt_entry               = '0;
        rpt_entry.kind          = KIND_REPORT;
        rpt_entry.status        = rpt_status;
        rpt_entry.chan_count    = s_command ? channels_reg : channels_next;
        rpt_entry.samp_rate     = s_command ? rate_reg     : rate_next;
        rpt_entry.bytes_per_sec = s_command ? brate_reg    : brate_next;
        rpt_entry.frame_bytes   = s_command ? align_reg    : align_next;
        rpt_entry.samp_bits     = s_command ? bits_reg     : bits_next;
        rpt_entry.payload_len   = s_command ? data_len_reg : data_len_next;
        rpt_entry.last          = 1'b1;

        data_entry               = '0;
        data_entry.kind          = KIND_AUDIO;
        data_entry.data_byte_res = s_data_byte;
        data_entry.last          = !rpt_valid;

        push = '0;
        if (emit_data) begin
            push.push0  = 1'b1;
            push.entry0 = data_entry;
            push.push1  = rpt_valid;
            push.entry1 = rpt_entry;
        end else if (rpt_valid) begin
            push.push0  = 1'b1;
            push.entry0 = rpt_entry;
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_RIFF;
            count_reg     <= '0;
            id_reg        <= '0;
            size_reg      <= '0;
            fmt_code_reg  <= '0;
            channels_reg  <= '0;
            rate_reg      <= '0;
            brate_reg     <= '0;
            align_reg     <= '0;
            bits_reg      <= '0;
            data_len_reg  <= '0;
            fmt_seen_reg  <= 1'b0;
            data_seen_reg <= 1'b0;
            done_reg      <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            id_reg        <= id_next;
            size_reg      <= size_next;
            fmt_code_reg  <= fmt_code_next;
            channels_reg  <= channels_next;
            rate_reg      <= rate_next;
            brate_reg     <= brate_next;
            align_reg     <= align_next;
            bits_reg      <= bits_next;
            data_len_reg  <= data_len_next;
            fmt_seen_reg  <= fmt_seen_next;
            data_seen_reg <= data_seen_next;
            done_reg      <= done_next;
        end
    end

endmodule

// ===== hw/rtl/whsp_queue.sv =====
// ----------------------------------------------------------------------------
// WAV header stream parser result queue
// Small circular queue with two write slots per cycle and one read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module whsp_queue import whsp_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  push_t   push,
    output logic    room,
    input  logic    pop,
    output logic    head_valid,
    output result_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

    result_t          mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_p1, wr_ptr_p2;

    function automatic logic [PTR_W-1:0] ptr_step(input logic [PTR_W-1:0] p);
        ptr_step = (p == LAST_SLOT) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    // Pointer and occupancy bookkeeping.
    assign wr_ptr_p1   = ptr_step(wr_ptr_reg);
    assign wr_ptr_p2   = ptr_step(wr_ptr_p1);
    assign wr_ptr_next = push.push1 ? wr_ptr_p2 : (push.push0 ? wr_ptr_p1 : wr_ptr_reg);
    assign rd_ptr_next = pop ? ptr_step(rd_ptr_reg) : rd_ptr_reg;
    assign count_next  = count_reg + CNT_W'(push.push0) + CNT_W'(push.push1)
                         - CNT_W'(pop);

    // A new request may bring two results, so keep two slots free.
    assign room       = (count_reg <= CNT_W'(DEPTH - 2));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];

    // Storage writes.
    always_ff @(posedge aclk) begin
        if (push.push0) begin
            mem[wr_ptr_reg] <= push.entry0;
        end
        if (push.push1) begin
            mem[wr_ptr_p1] <= push.entry1;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/whsp_back.sv =====
// ----------------------------------------------------------------------------
// WAV header stream parser back end
// Output register that drains the result queue onto the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module whsp_back import whsp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        head_valid,
    input  result_t     head,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_data_byte_res,
    output logic [1:0]  m_status,
    output logic [15:0] m_chan_count,
    output logic [31:0] m_samp_rate,
    output logic [31:0] m_bytes_per_sec,
    output logic [15:0] m_frame_bytes,
    output logic [15:0] m_samp_bits,
    output logic [31:0] m_payload_len,
    output logic        m_last
);

    logic    valid_reg, valid_next;
    result_t out_reg;

    // Load the next result when the register is empty or being taken.
    assign pop        = head_valid && (!valid_reg || m_ready);
    assign valid_next = pop ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg <= head;
        end
    end

    // Result channel fields.
    assign m_valid         = valid_reg;
    assign m_kind          = out_reg.kind;
    assign m_data_byte_res = out_reg.data_byte_res;
    assign m_status        = out_reg.status;
    assign m_chan_count    = out_reg.chan_count;
    assign m_samp_rate     = out_reg.samp_rate;
    assign m_bytes_per_sec = out_reg.bytes_per_sec;
    assign m_frame_bytes   = out_reg.frame_bytes;
    assign m_samp_bits     = out_reg.samp_bits;
    assign m_payload_len   = out_reg.payload_len;
    assign m_last          = out_reg.last;

endmodule

// ===== hw/rtl/wav_header_stream_parser.sv =====
// ----------------------------------------------------------------------------
// WAV header stream parser
// Path: each result is written into the queue and then loaded into the output register.
// Throughput: one request per cycle; s_ready falls while under two queue slots are free.
// Reset: synchronous aresetn low empties the queue and returns the parser to the RIFF tag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "wav_header_stream_parser_macros.svh"

module wav_header_stream_parser import whsp_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_data_byte_res,
    output logic [1:0]  m_status,
    output logic [15:0] m_chan_count,
    output logic [31:0] m_samp_rate,
    output logic [31:0] m_bytes_per_sec,
    output logic [15:0] m_frame_bytes,
    output logic [15:0] m_samp_bits,
    output logic [31:0] m_payload_len,
    output logic        m_last
);

    push_t   push;
    logic    q_room;
    logic    q_valid;
    logic    q_pop;
    result_t q_head;
    logic    pair_ok;
    logic    lone_report;

    // Byte classifier and chunk walker.
    whsp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_data_byte (s_data_byte),
        .q_room      (q_room),
        .push        (push)
    );

    // Decoupling queue between the parser and the output stage.
    whsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .room       (q_room),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    // Output register.
    whsp_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head_valid      (q_valid),
        .head            (q_head),
        .pop             (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_data_byte_res (m_data_byte_res),
        .m_status        (m_status),
        .m_chan_count    (m_chan_count),
        .m_samp_rate     (m_samp_rate),
        .m_bytes_per_sec (m_bytes_per_sec),
        .m_frame_bytes   (m_frame_bytes),
        .m_samp_bits     (m_samp_bits),
        .m_payload_len   (m_payload_len),
        .m_last          (m_last)
    );

    // Shapes of the queue writes checked below.
    assign pair_ok     = push.push0 && (push.entry0.kind == KIND_AUDIO)
                         && (push.entry1.kind == KIND_REPORT);
    assign lone_report = push.push0 && (push.entry0.kind == KIND_REPORT);

    // Results are only produced by an accepted request.
    `WHSP_IMPLIES(a_push_on_accept, push.push0, s_valid && s_ready, "push without request")
    // A pair of results is always an audio byte followed by its report.
    `WHSP_IMPLIES(a_pair_order, push.push1, pair_ok, "bad result pair")
    // A lone report closes its request.
    `WHSP_IMPLIES(a_report_last, lone_report, push.entry0.last && !push.push1, "report not last")
    // The output stage never drains an empty queue.
    `WHSP_ASSERT(a_pop_nonempty, !q_pop || q_valid, "pop from empty queue")

endmodule
